// ===== rtl/cmp_pkg.sv =====
// Shared types, constants and helper functions of the tilt-compensated compass.
`timescale 1ns / 1ps
package cmp_pkg;

    localparam int VW        = 36;  // vectoring datapath width
    localparam int ZW        = 26;  // angle width, 2^-16 degree units
    localparam int RW        = 34;  // sin/cos datapath width, Q30
    localparam int MAX_STEPS = 24;  // upper bound on the CORDIC steps per chain

    localparam logic signed [ZW-1:0] HALF_TURN = 26'sd11796480;
    localparam logic signed [24:0]   GAIN_Q24  = 25'sd10188014;
    localparam logic signed [RW-1:0] GAIN_Q30  = 34'sd652032874;
    localparam logic signed [ZW-1:0] OUT_LIMIT = 26'sd23040;

    typedef struct packed {
        logic signed [VW-1:0] x;
        logic signed [VW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 zero;
    } vec_t;

    typedef struct packed {
        logic signed [RW-1:0] x;
        logic signed [RW-1:0] y;
        logic signed [ZW-1:0] z;
    } rot_t;

    // round(atan(2^-i) * 65536), degrees
    function automatic logic signed [ZW-1:0] atan_deg(input int idx);
        logic signed [ZW-1:0] a;
        case (idx)
            0:       a = 26'sd2949120;
            1:       a = 26'sd1740967;
            2:       a = 26'sd919879;
            3:       a = 26'sd466945;
            4:       a = 26'sd234379;
            5:       a = 26'sd117304;
            6:       a = 26'sd58666;
            7:       a = 26'sd29335;
            8:       a = 26'sd14668;
            9:       a = 26'sd7334;
            10:      a = 26'sd3667;
            11:      a = 26'sd1833;
            12:      a = 26'sd917;
            13:      a = 26'sd458;
            14:      a = 26'sd229;
            15:      a = 26'sd115;
            16:      a = 26'sd57;
            17:      a = 26'sd29;
            18:      a = 26'sd14;
            19:      a = 26'sd7;
            20:      a = 26'sd4;
            21:      a = 26'sd2;
            22:      a = 26'sd1;
            default: a = 26'sd0;
        endcase
        return a;
    endfunction

    // Fold a left half-plane vector into the right half-plane, flag the zero vector.
    function automatic vec_t vec_pre(input logic signed [VW-1:0] x,
                                     input logic signed [VW-1:0] y);
        vec_t v;
        v.zero = (x == '0) && (y == '0);
        if (x[VW-1]) begin
            v.x = -x;
            v.y = -y;
            if (y[VW-1])
                v.z = -HALF_TURN;
            else
                v.z = HALF_TURN;
        end
        else begin
            v.x = x;
            v.y = y;
            v.z = '0;
        end
        return v;
    endfunction

    // Round to 1/128 degree and saturate.
    function automatic logic signed [15:0] angle_out(input logic signed [ZW-1:0] z);
        logic signed [ZW-1:0] s;
        s = (z + 26'sd256) >>> 9;
        if (s > OUT_LIMIT)
            s = OUT_LIMIT;
        if (s < -OUT_LIMIT)
            s = -OUT_LIMIT;
        return s[15:0];
    endfunction

endpackage

// ===== rtl/cmp_in_if.sv =====
// Sensor sample channel: accelerometer and magnetometer vectors.
`timescale 1ns / 1ps
interface cmp_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] magn_x;
    logic signed [15:0] magn_y;
    logic signed [15:0] magn_z;

    modport source (output valid, accel_x, accel_y, accel_z, magn_x, magn_y, magn_z,
                    input ready);
    modport sink   (input valid, accel_x, accel_y, accel_z, magn_x, magn_y, magn_z,
                    output ready);
endinterface

// ===== rtl/cmp_out_if.sv =====
// Result channel: pitch, roll and heading.
`timescale 1ns / 1ps
interface cmp_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] pitch_angle;
    logic signed [15:0] roll_angle;
    logic signed [15:0] heading_angle;

    modport source (output valid, pitch_angle, roll_angle, heading_angle, input ready);
    modport sink   (input valid, pitch_angle, roll_angle, heading_angle, output ready);
endinterface

// ===== rtl/cmp_vec_cell.sv =====
// One vectoring CORDIC step: drives y toward zero, accumulates the angle.
`timescale 1ns / 1ps
module cmp_vec_cell
    import cmp_pkg::*;
#(
    parameter int IDX = 0
)
(
    input  logic clk,
    input  logic en,
    input  vec_t d,
    output vec_t q
);

    vec_t                 q_reg;
    vec_t                 q_next;
    logic signed [VW-1:0] xs;
    logic signed [VW-1:0] ys;

    always_comb
    begin
        xs     = $signed(d.x) >>> IDX;
        ys     = $signed(d.y) >>> IDX;
        q_next = d;
        if (!d.y[VW-1])
        begin
            q_next.x = d.x + ys;
            q_next.y = d.y - xs;
            q_next.z = d.z + atan_deg(IDX);
        end
        else
        begin
            q_next.x = d.x - ys;
            q_next.y = d.y + xs;
            q_next.z = d.z - atan_deg(IDX);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            q_reg <= q_next;
    end

    assign q = q_reg;

endmodule

// ===== rtl/cmp_rot_cell.sv =====
// One rotation CORDIC step: drives the residual angle toward zero.
`timescale 1ns / 1ps
module cmp_rot_cell
    import cmp_pkg::*;
#(
    parameter int IDX = 0
)
(
    input  logic clk,
    input  logic en,
    input  rot_t d,
    output rot_t q
);

    rot_t                 q_reg;
    rot_t                 q_next;
    logic signed [RW-1:0] xs;
    logic signed [RW-1:0] ys;

    always_comb
    begin
        xs     = $signed(d.x) >>> IDX;
        ys     = $signed(d.y) >>> IDX;
        q_next = d;
        if (!d.z[ZW-1])
        begin
            q_next.x = d.x - ys;
            q_next.y = d.y + xs;
            q_next.z = d.z - atan_deg(IDX);
        end
        else
        begin
            q_next.x = d.x + ys;
            q_next.y = d.y - xs;
            q_next.z = d.z + atan_deg(IDX);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            q_reg <= q_next;
    end

    assign q = q_reg;

endmodule

// ===== rtl/tilt_compensated_compass.sv =====
// Tilt-compensated compass: pipelined CORDIC chains from raw samples to three angles.
// S = min(CORDIC_STEPS, 24) is the depth, in cells, of each of the four CORDIC chains.
// Throughput: one beat per cycle; every stage is a cell or register that advances together,
//   and the whole pipe holds while a result waits on the output.
// Reset: clears the per-stage valid bits only; the datapath is not reset.
`timescale 1ns / 1ps
module tilt_compensated_compass
    import cmp_pkg::*;
#(
    parameter int CORDIC_STEPS = 16,
    parameter int SAMPLE_BITS  = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    cmp_in_if.sink    sensor,
    cmp_out_if.source angles
);

    localparam int S   = (CORDIC_STEPS > MAX_STEPS) ? MAX_STEPS : CORDIC_STEPS;
    localparam int SH  = (SAMPLE_BITS < 16) ? 16 - SAMPLE_BITS : 0;
    localparam int NST = 4 * S + 9;   // pipeline stages including input and output
    localparam int GW  = VW + 25;     // magnitude gain product
    localparam int QW  = 2 * RW;      // sin/cos product
    localparam int PW  = 2 * VW;      // sample times sin/cos product

    localparam logic signed [GW-1:0] RND24 = GW'(64'sd8388608);
    localparam logic signed [QW-1:0] RND29 = QW'(64'sd536870912);
    localparam logic signed [PW-1:0] RNDP  = PW'(64'sd536870912);

    // Sign-extend a raw sample, drop low bits past SAMPLE_BITS, scale to ~2^30.
    function automatic logic signed [VW-1:0] scale(input logic signed [15:0] raw);
        logic signed [VW-1:0] s;
        s = {{(VW-16){raw[15]}}, raw};
        s = s >>> SH;
        return s <<< (SH + 15);
    endfunction

    // Whole-pipe advance: move when the output slot is empty or being taken.
    logic             en;
    logic [NST-1:0]   vld_reg;

    assign en           = !vld_reg[NST-1] || angles.ready;
    assign sensor.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[NST-2:0], sensor.valid};
    end

    // Input stage: register and scale the six samples.
    logic signed [VW-1:0] ax_reg, ay_reg, az_reg, mx_reg, my_reg, mz_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ax_reg <= scale(sensor.accel_x);
            ay_reg <= scale(sensor.accel_y);
            az_reg <= scale(sensor.accel_z);
            mx_reg <= scale(sensor.magn_x);
            my_reg <= scale(sensor.magn_y);
            mz_reg <= scale(sensor.magn_z);
        end
    end

    // Chain 1: lengths |(ay, az)| for pitch and |(ax, az)| for roll.
    vec_t c1a [S+1];
    vec_t c1b [S+1];
    vec_t c2a [S+1];
    vec_t c2b [S+1];
    vec_t c4  [S+1];
    rot_t rp  [S+1];
    rot_t rr  [S+1];

    assign c1a[0] = vec_pre(ay_reg, az_reg);
    assign c1b[0] = vec_pre(ax_reg, az_reg);

    genvar gi;
    generate
        for (gi = 0; gi < S; gi++)
        begin : g_chain1
            cmp_vec_cell #(.IDX(gi)) u_a (.clk(clk), .en(en), .d(c1a[gi]), .q(c1a[gi+1]));
            cmp_vec_cell #(.IDX(gi)) u_b (.clk(clk), .en(en), .d(c1b[gi]), .q(c1b[gi+1]));
        end
    endgenerate

    // Gain correction: multiply, then round back by 2^24.
    logic signed [GW-1:0] g1a_reg, g1b_reg, g1a_next, g1b_next, g2a_sum, g2b_sum;
    logic signed [VW-1:0] r1_reg, r2_reg;

    always_comb
    begin
        if (c1a[S].zero)
            g1a_next = '0;
        else
            g1a_next = $signed(c1a[S].x) * GAIN_Q24;
        if (c1b[S].zero)
            g1b_next = '0;
        else
            g1b_next = $signed(c1b[S].x) * GAIN_Q24;
        g2a_sum = g1a_reg + RND24;
        g2b_sum = g1b_reg + RND24;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            g1a_reg <= g1a_next;
            g1b_reg <= g1b_next;
            r1_reg  <= $signed(g2a_sum[VW+23:24]);
            r2_reg  <= $signed(g2b_sum[VW+23:24]);
        end
    end

    // Delay lines: ax/ay to chain 2, magnetometer to the products, angles to the output.
    logic signed [VW-1:0] dax_reg [S+2];
    logic signed [VW-1:0] day_reg [S+2];
    logic signed [VW-1:0] dmx_reg [3*S+5];
    logic signed [VW-1:0] dmy_reg [3*S+5];
    logic signed [VW-1:0] dmz_reg [3*S+5];
    logic signed [ZW-1:0] dpt_reg [2*S+4];
    logic signed [ZW-1:0] drl_reg [2*S+4];
    logic signed [ZW-1:0] pitch_reg, roll_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dax_reg[0] <= ax_reg;
            day_reg[0] <= ay_reg;
            for (int k = 1; k < S + 2; k++)
            begin
                dax_reg[k] <= dax_reg[k-1];
                day_reg[k] <= day_reg[k-1];
            end
            dmx_reg[0] <= mx_reg;
            dmy_reg[0] <= my_reg;
            dmz_reg[0] <= mz_reg;
            for (int k = 1; k < 3 * S + 5; k++)
            begin
                dmx_reg[k] <= dmx_reg[k-1];
                dmy_reg[k] <= dmy_reg[k-1];
                dmz_reg[k] <= dmz_reg[k-1];
            end
            dpt_reg[0] <= pitch_reg;
            drl_reg[0] <= roll_reg;
            for (int k = 1; k < 2 * S + 4; k++)
            begin
                dpt_reg[k] <= dpt_reg[k-1];
                drl_reg[k] <= drl_reg[k-1];
            end
        end
    end

    // Chain 2: pitch = atan2(ax, r1), roll = atan2(ay, r2).
    assign c2a[0] = vec_pre(r1_reg, dax_reg[S+1]);
    assign c2b[0] = vec_pre(r2_reg, day_reg[S+1]);

    generate
        for (gi = 0; gi < S; gi++)
        begin : g_chain2
            cmp_vec_cell #(.IDX(gi)) u_a (.clk(clk), .en(en), .d(c2a[gi]), .q(c2a[gi+1]));
            cmp_vec_cell #(.IDX(gi)) u_b (.clk(clk), .en(en), .d(c2b[gi]), .q(c2b[gi+1]));
        end
    endgenerate

    // A zero vector gives a zero angle.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (c2a[S].zero)
                pitch_reg <= '0;
            else
                pitch_reg <= c2a[S].z;
            if (c2b[S].zero)
                roll_reg <= '0;
            else
                roll_reg <= c2b[S].z;
        end
    end

    // Chain 3: cos/sin of pitch and roll in Q30.
    assign rp[0].x = GAIN_Q30;
    assign rp[0].y = '0;
    assign rp[0].z = pitch_reg;
    assign rr[0].x = GAIN_Q30;
    assign rr[0].y = '0;
    assign rr[0].z = roll_reg;

    generate
        for (gi = 0; gi < S; gi++)
        begin : g_chain3
            cmp_rot_cell #(.IDX(gi)) u_p (.clk(clk), .en(en), .d(rp[gi]), .q(rp[gi+1]));
            cmp_rot_cell #(.IDX(gi)) u_r (.clk(clk), .en(en), .d(rr[gi]), .q(rr[gi+1]));
        end
    endgenerate

    // De-rotation: Q30 cross products, round, sample products, sum and round.
    logic signed [QW-1:0] pss_reg, pcs_reg, pss_sum, pcs_sum;
    logic signed [RW-1:0] cp1_reg, cr1_reg, sr1_reg, cp2_reg, cr2_reg, sr2_reg;
    logic signed [VW-1:0] qs_reg, qc_reg, hx_reg, hy_reg;
    logic signed [PW-1:0] ma_reg, mb_reg, mc_reg, md_reg, me_reg, hx_sum, hy_sum;

    assign pss_sum = pss_reg + RND29;
    assign pcs_sum = pcs_reg + RND29;
    assign hx_sum  = ma_reg + mb_reg + mc_reg + RNDP;
    assign hy_sum  = md_reg - me_reg + RNDP;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pss_reg <= $signed(rr[S].y) * $signed(rp[S].y);
            pcs_reg <= $signed(rr[S].x) * $signed(rp[S].y);
            cp1_reg <= rp[S].x;
            cr1_reg <= rr[S].x;
            sr1_reg <= rr[S].y;

            qs_reg  <= $signed(pss_sum[VW+29:30]);
            qc_reg  <= $signed(pcs_sum[VW+29:30]);
            cp2_reg <= cp1_reg;
            cr2_reg <= cr1_reg;
            sr2_reg <= sr1_reg;

            ma_reg  <= dmx_reg[3*S+4] * cp2_reg;
            mb_reg  <= dmy_reg[3*S+4] * qs_reg;
            mc_reg  <= dmz_reg[3*S+4] * qc_reg;
            md_reg  <= dmy_reg[3*S+4] * cr2_reg;
            me_reg  <= dmz_reg[3*S+4] * sr2_reg;

            hx_reg  <= $signed(hx_sum[VW+29:30]);
            hy_reg  <= $signed(hy_sum[VW+29:30]);
        end
    end

    // Chain 4: heading = atan2(-hy, hx).
    assign c4[0] = vec_pre(hx_reg, -hy_reg);

    generate
        for (gi = 0; gi < S; gi++)
        begin : g_chain4
            cmp_vec_cell #(.IDX(gi)) u_h (.clk(clk), .en(en), .d(c4[gi]), .q(c4[gi+1]));
        end
    endgenerate

    // Output register: round to 1/128 degree and saturate.
    logic signed [ZW-1:0] yaw;
    logic signed [15:0]   pitch_out_reg, roll_out_reg, yaw_out_reg;

    always_comb
    begin
        if (c4[S].zero)
            yaw = '0;
        else
            yaw = c4[S].z;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pitch_out_reg <= angle_out(dpt_reg[2*S+3]);
            roll_out_reg  <= angle_out(drl_reg[2*S+3]);
            yaw_out_reg   <= angle_out(yaw);
        end
    end

    assign angles.valid         = vld_reg[NST-1];
    assign angles.pitch_angle   = pitch_out_reg;
    assign angles.roll_angle    = roll_out_reg;
    assign angles.heading_angle = yaw_out_reg;

endmodule
